### hdl/udf_pkg.sv
// Shared constants and types of the unsigned decimal formatter.
`default_nettype none

package udf_pkg;

  localparam int VALUE_W        = 32;
  localparam int PAD_W          = 4;
  localparam int CHAR_W         = 8;
  localparam int DIGIT_W        = 4;
  localparam int MAX_DIGITS_DEF = 10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Commands from the sequencer to the converter.
  typedef struct packed {
    logic start;
    logic digit_shift;
  } conv_ctrl_t;

  // Status of the converter seen by the sequencer.
  typedef struct packed {
    logic               busy;
    logic               ovf;
    logic [DIGIT_W-1:0] top_digit;
  } conv_stat_t;

endpackage

`default_nettype wire

### hdl/udf_in_if.sv
// Input channel of the formatter: a binary value and its pad width.
`default_nettype none

interface udf_in_if;
  logic                       valid;
  logic                       ready;
  logic [udf_pkg::VALUE_W-1:0] value;
  logic [udf_pkg::PAD_W-1:0]   pad_width;

  modport source (output valid, output value, output pad_width, input ready);
  modport sink   (input valid, input value, input pad_width, output ready);
endinterface

`default_nettype wire

### hdl/udf_out_if.sv
// Output channel of the formatter: one ASCII character per transfer.
`default_nettype none

interface udf_out_if;
  logic                       valid;
  logic                       ready;
  logic [udf_pkg::CHAR_W-1:0] char_code;
  logic                       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

### hdl/udf_bcd_conv.sv
// Bit-serial shift-add-3 binary to BCD converter with a digit shift-out path.
`default_nettype none

module udf_bcd_conv #(
  parameter int MAX_DIGITS = udf_pkg::MAX_DIGITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire udf_pkg::conv_ctrl_t     ctrl,
  input  wire [udf_pkg::VALUE_W-1:0]   value,
  output udf_pkg::conv_stat_t          stat
);

  localparam int BCD_W = MAX_DIGITS * udf_pkg::DIGIT_W;
  localparam int CNT_W = $clog2(udf_pkg::VALUE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(udf_pkg::VALUE_W - 1);

  logic [udf_pkg::VALUE_W-1:0] bits;
  logic [BCD_W-1:0]            bcd;
  logic [BCD_W-1:0]            adj;
  logic [CNT_W-1:0]            cnt;
  logic                        running;
  logic                        ovf;

  // Every digit of five or more gets three added before the doubling shift.
  always_comb begin
    logic [udf_pkg::DIGIT_W-1:0] d;
    d = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      d = bcd[i*udf_pkg::DIGIT_W +: udf_pkg::DIGIT_W];
      adj[i*udf_pkg::DIGIT_W +: udf_pkg::DIGIT_W] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (ctrl.start) begin
      running <= 1'b1;
    end else if (running && cnt == CNT_LAST) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bits <= value;
      bcd  <= '0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else if (running) begin
      bcd  <= {adj[BCD_W-2:0], bits[udf_pkg::VALUE_W-1]};
      bits <= {bits[udf_pkg::VALUE_W-2:0], 1'b0};
      // A one leaving the top digit means the value has more digits than fit.
      ovf  <= ovf | adj[BCD_W-1];
      cnt  <= cnt + 1'b1;
    end else if (ctrl.digit_shift) begin
      bcd <= {bcd[BCD_W-udf_pkg::DIGIT_W-1:0], {udf_pkg::DIGIT_W{1'b0}}};
    end
  end

  assign stat.busy      = running;
  assign stat.ovf       = ovf;
  assign stat.top_digit = bcd[BCD_W-1 -: udf_pkg::DIGIT_W];

endmodule

`default_nettype wire

### hdl/unsigned_decimal_formatter.sv
// Top level of the unsigned decimal formatter: sequencer and output register.
`default_nettype none

// Each accepted value is converted to BCD one bit per cycle by a shift-add-3
// register, then the digit positions are scanned from the most significant
// one down, one position per cycle, though a position that prints waits while
// the output is stalled, and each position gives a space, a digit or nothing.
// No new value is taken until the scan of the last one has ended. The last
// character of an item sits in the output register while the next item is
// accepted. A value with more digits than MAX_DIGITS keeps only its low digits,
// and all of them are printed. Pad widths above MAX_DIGITS act as MAX_DIGITS.
module unsigned_decimal_formatter #(
  parameter int MAX_DIGITS = udf_pkg::MAX_DIGITS_DEF
) (
  input wire        clk,
  input wire        rst,
  udf_in_if.sink    items,
  udf_out_if.source chars
);

  localparam int POS_W = $clog2(MAX_DIGITS);
  localparam int CMP_W = (POS_W > udf_pkg::PAD_W) ? POS_W : udf_pkg::PAD_W;
  localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_DIGITS - 1);

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    CONV = 3'b010,
    SCAN = 3'b100
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [udf_pkg::PAD_W-1:0]  pad;
  logic [POS_W-1:0]           pos;
  logic                       seen;
  logic                       out_valid;
  logic [udf_pkg::CHAR_W-1:0] out_char;
  logic                       out_last;

  udf_pkg::conv_ctrl_t ctrl;
  udf_pkg::conv_stat_t stat;

  logic accept;
  logic nz;
  logic emit;
  logic can_load;
  logic step;

  udf_bcd_conv #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_conv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .value(items.value),
    .stat (stat)
  );

  assign items.ready = (state == IDLE);
  assign accept      = items.valid && items.ready;

  // A position prints a digit once a nonzero digit has been met at or above
  // it; the units position always prints. Leading zeros inside the pad width
  // print as spaces and the rest are skipped.
  assign nz       = seen || stat.ovf || (stat.top_digit != '0) || (pos == '0);
  assign emit     = nz || (CMP_W'(pos) < CMP_W'(pad));
  assign can_load = !out_valid || chars.ready;
  assign step     = (state == SCAN) && (!emit || can_load);

  assign ctrl.start       = accept;
  assign ctrl.digit_shift = step;

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) state_next = CONV;
      end
      CONV: begin
        if (!stat.busy) state_next = SCAN;
      end
      SCAN: begin
        if (step && pos == '0) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pad  <= items.pad_width;
      pos  <= POS_TOP;
      seen <= 1'b0;
    end else if (step) begin
      seen <= nz;
      if (pos != '0) pos <= pos - 1'b1;
    end
    if (step && emit) begin
      out_char <= nz ? (udf_pkg::CHAR_ZERO + {4'b0000, stat.top_digit})
                     : udf_pkg::CHAR_SPACE;
      out_last <= (pos == '0);
    end
  end

  assign chars.valid     = out_valid;
  assign chars.char_code = out_char;
  assign chars.last      = out_last;

`ifndef SYNTHESIS
  a_idle_conv_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !stat.busy)
    else $error("converter running while the formatter is idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (stat.busy && state == CONV))
    else $error("accepted item did not start a conversion");

  a_scan_after_conv: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> !stat.busy)
    else $error("digit scan overlaps the conversion");

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.last) |-> (chars.char_code != udf_pkg::CHAR_SPACE))
    else $error("final character of a number is a space");

  a_done_has_last: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN && state_next == IDLE) |=> (out_valid && out_last))
    else $error("scan ended without a final character");
`endif

endmodule

`default_nettype wire

### tb/sv/unsigned_decimal_formatter_test.sv
// Self-checking testbench of the unsigned decimal formatter.
`timescale 1ns / 1ps

module unsigned_decimal_formatter_test;

  localparam int DIGITS      = udf_pkg::MAX_DIGITS_DEF;
  localparam int RANDOM_NUMS = 128;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic [udf_pkg::VALUE_W-1:0] value;
    logic [udf_pkg::PAD_W-1:0]   pad_width;
  } number_t;

  typedef struct packed {
    logic [udf_pkg::CHAR_W-1:0] code;
    logic                       last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  udf_in_if  number_bus ();
  udf_out_if text_bus ();

  unsigned_decimal_formatter i_dut (
    .clk   (clk),
    .rst   (rst),
    .items (number_bus),
    .chars (text_bus)
  );

  number_t    number_queue [$];
  text_char_t expected_chars [$];

  int errors        = 0;
  int numbers_taken = 0;
  int chars_seen    = 0;
  int directed_nums = 0;
  int tx_wait       = 0;
  int rx_wait       = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  bit tx_calm       = 1'b0;
  bit rx_calm       = 1'b1;

  always #5 clk = ~clk;

  // Works out the characters one number prints to and queues them in order.
  function automatic void predict_text(input logic [udf_pkg::VALUE_W-1:0] value,
                                       input logic [udf_pkg::PAD_W-1:0] pad_width);
    logic [3:0]  digs [DIGITS];
    logic [63:0] rest;
    int          ndig;
    int          pad;
    int          total;
    int          spaces;
    text_char_t  ch;
    rest = 64'(value);
    for (int i = 0; i < DIGITS; i++) begin
      digs[i] = 4'(rest % 10);
      rest    = rest / 10;
    end
    ndig = 1;
    for (int i = 0; i < DIGITS; i++) begin
      if (digs[i] != 0) ndig = i + 1;
    end
    // Digits above the converter's positions are lost, but all positions print.
    if (rest != 0) ndig = DIGITS;
    pad    = (pad_width > DIGITS) ? DIGITS : int'(pad_width);
    total  = (pad > ndig) ? pad : ndig;
    spaces = total - ndig;
    for (int k = 0; k < total; k++) begin
      if (k < spaces) begin
        ch.code = udf_pkg::CHAR_SPACE;
      end else begin
        ch.code = udf_pkg::CHAR_ZERO + {4'b0000, digs[ndig - 1 - (k - spaces)]};
      end
      ch.last = (k == total - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin : number_driver
    number_t nxt;
    if (rst) begin
      number_bus.valid     <= 1'b0;
      number_bus.value     <= '0;
      number_bus.pad_width <= '0;
      tx_wait = 0;
    end else begin
      if (number_bus.valid && number_bus.ready) begin
        predict_text(number_bus.value, number_bus.pad_width);
        numbers_taken <= numbers_taken + 1;
      end
      if (!number_bus.valid || number_bus.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          number_bus.valid <= 1'b0;
        end else if (number_queue.size() != 0) begin
          nxt = number_queue.pop_front();
          number_bus.valid     <= 1'b1;
          number_bus.value     <= nxt.value;
          number_bus.pad_width <= nxt.pad_width;
          tx_wait = tx_calm ? 0 : $urandom_range(0, 18);
          if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
        end else begin
          number_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : text_monitor
    text_char_t want;
    if (rst) begin
      text_bus.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (text_bus.valid && text_bus.ready) begin
        chars_seen <= chars_seen + 1;
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected character: expected none, got %h last %b",
                   $time, text_bus.char_code, text_bus.last);
        end else begin
          want = expected_chars.pop_front();
          if (text_bus.char_code !== want.code) begin
            errors++;
            $display("%0t: char_code mismatch: expected %h, got %h",
                     $time, want.code, text_bus.char_code);
          end
          if (text_bus.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch: expected %b, got %b",
                     $time, want.last, text_bus.last);
          end
        end
        rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      text_bus.ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // One long output stall partway through, so the block backs up onto its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && numbers_taken == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    number_t n;

    // Zero, the largest value, several digit counts, and pads around the text length.
    number_queue.push_back('{32'd0, 4'd0});
    number_queue.push_back('{32'd0, 4'd10});
    number_queue.push_back('{32'd0, 4'd15});
    number_queue.push_back('{32'hFFFF_FFFF, 4'd0});
    number_queue.push_back('{32'hFFFF_FFFF, 4'd15});
    number_queue.push_back('{32'd1, 4'd1});
    number_queue.push_back('{32'd9, 4'd2});
    number_queue.push_back('{32'd10, 4'd0});
    number_queue.push_back('{32'd99, 4'd3});
    number_queue.push_back('{32'd100, 4'd9});
    number_queue.push_back('{32'd12345, 4'd4});
    number_queue.push_back('{32'd12345, 4'd5});
    number_queue.push_back('{32'd12345, 4'd6});
    number_queue.push_back('{32'd999999999, 4'd10});
    number_queue.push_back('{32'd1000000000, 4'd11});
    number_queue.push_back('{32'd4000000000, 4'd12});
    number_queue.push_back('{32'h8000_0000, 4'd13});
    number_queue.push_back('{32'h5555_5555, 4'd14});
    number_queue.push_back('{32'hAAAA_AAAA, 4'd7});
    number_queue.push_back('{32'd7, 4'd8});
    number_queue.push_back('{32'd1000, 4'd11});
    number_queue.push_back('{32'd4294967294, 4'd10});
    directed_nums = number_queue.size();

    for (int i = 0; i < RANDOM_NUMS; i++) begin
      case ($urandom_range(0, 3))
        0: n.value = $urandom();
        1: n.value = $urandom_range(0, 9);
        2: n.value = $urandom_range(0, 99999);
        default: n.value = $urandom() >> $urandom_range(0, 31);
      endcase
      n.pad_width = 4'($urandom_range(0, 15));
      number_queue.push_back(n);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (number_queue.size() != 0 || number_bus.valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Formatted %0d numbers (%0d directed, rest random), checked %0d characters,",
             numbers_taken, directed_nums, chars_seen);
    $display("with random gaps on both sides and one long output stall.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d characters still expected.", expected_chars.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
